### design/mspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspl_pkg
// Shared widths, register codes, reset values and stage types of the motor
// speed PID loop.
// ----------------------------------------------------------------------------
package mspl_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TargetW = 16;
  localparam int unsigned SpeedW  = 17;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned DiffW   = 19;
  localparam int unsigned IntegW  = 22;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 20;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned DutyW   = 31;
  localparam int unsigned SumW    = 40;
  localparam int unsigned FracW   = 8;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = LimitW;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 112;

  localparam logic [GainW-1:0]  GainPropRst  = 16'd25600;
  localparam logic [GainW-1:0]  GainIntegRst = 16'd1408;
  localparam logic [GainW-1:0]  GainDerivRst = 16'd0;
  localparam logic [LimitW-1:0] IntegLimRst  = 20'd12000;

  localparam logic signed [SumW-1:0] DriveMax = 40'sd2147483647;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_PROP  = 2'd0,
    CFG_GAIN_INTEG = 2'd1,
    CFG_GAIN_DERIV = 2'd2,
    CFG_INTEG_LIM  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0] prop;
    logic [GainW-1:0] integ;
    logic [GainW-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] acc;
    logic signed [DiffW-1:0]  diff;
  } err_stage_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic signed [DriveW-1:0] drive;
    logic [DutyW-1:0]         duty_fwd;
    logic [DutyW-1:0]         duty_rev;
  } result_t;

endpackage

### design/mspl_law.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspl_law
// PID sum of the error terms, Q8.8 scaling with truncation toward zero,
// drive saturation and the split into forward and reverse duties.
// ----------------------------------------------------------------------------
module mspl_law (
  input  mspl_pkg::err_stage_t stage_i,
  input  mspl_pkg::gains_t     gains_i,
  output mspl_pkg::result_t    result_o
);
  import mspl_pkg::*;

  logic signed [GainW:0]        kp;
  logic signed [GainW:0]        ki;
  logic signed [GainW:0]        kd;
  logic signed [GainW+ErrW:0]   p_term;
  logic signed [GainW+IntegW:0] i_term;
  logic signed [GainW+DiffW:0]  d_term;
  logic signed [SumW-1:0]       sum;
  logic signed [SumW-1:0]       biased;
  logic signed [SumW-1:0]       scaled;
  logic signed [DriveW-1:0]     drive;

  assign kp = $signed({1'b0, gains_i.prop});
  assign ki = $signed({1'b0, gains_i.integ});
  assign kd = $signed({1'b0, gains_i.deriv});

  assign p_term = kp * stage_i.err;
  assign i_term = ki * stage_i.acc;
  assign d_term = kd * stage_i.diff;

  assign sum = SumW'(p_term) + SumW'(i_term) + SumW'(d_term);

  // bias negatives so the arithmetic shift truncates toward zero
  assign biased = sum[SumW-1] ? sum + SumW'((1 << FracW) - 1) : sum;
  assign scaled = biased >>> FracW;

  always_comb begin
    if (scaled > DriveMax) begin
      drive = DriveW'(DriveMax);
    end else if (scaled < -DriveMax) begin
      drive = DriveW'(-DriveMax);
    end else begin
      drive = scaled[DriveW-1:0];
    end
  end

  always_comb begin
    result_o.speed = stage_i.speed;
    result_o.drive = drive;
    if (drive[DriveW-1]) begin
      result_o.duty_fwd = '0;
      result_o.duty_rev = DutyW'(-drive);
    end else begin
      result_o.duty_fwd = drive[DutyW-1:0];
      result_o.duty_rev = '0;
    end
  end

endmodule

### design/motor_speed_pid_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_speed_pid_loop
// Positional PID speed controller with clamped integral and split PWM duty.
// ----------------------------------------------------------------------------
// One beat in, one beat out: a new tick is taken every clock cycle while the
// output is being taken, and its result is registered in the error stage and
// then in the output register. With both stages full and the output stalled
// the input is held off. The first stage signs the encoder count, forms the
// error, clamps the integral and updates the integral and previous-error
// state; the second stage holds the three gain multiplies and their sum,
// which set the clock period. Gains and the integral limit must be written
// through the config port only while no tick is in flight; the block itself
// does not enforce it. Input tdata, from bit 0: count_raw[15:0], dir_pin[16],
// speed_target[32:17]. Output tdata, from bit 0: speed_signed[16:0],
// drive[48:17], duty_fwd[79:49], duty_rev[110:80].
// ----------------------------------------------------------------------------
module motor_speed_pid_loop (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [mspl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mspl_pkg::CfgDataW-1:0]  cfg_wdata_i,

  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // count_raw, dir_pin, speed_target, zero pad
  input  logic [mspl_pkg::InDataW-1:0]   s_axis_tdata_i,

  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // speed_signed, drive, duty_fwd, duty_rev, zero pad
  output logic [mspl_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import mspl_pkg::*;

  logic [GainW-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [LimitW-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= GainPropRst;
      gain_integ_q <= GainIntegRst;
      gain_deriv_q <= GainDerivRst;
      lim_q        <= IntegLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GAIN_PROP:  gain_prop_q  <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_INTEG: gain_integ_q <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_DERIV: gain_deriv_q <= cfg_wdata_i[GainW-1:0];
        CFG_INTEG_LIM:  lim_q        <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic a_valid_q, a_valid_d;
  logic m_valid_q, m_valid_d;
  logic s_acc, adv;

  assign s_axis_tready_o = !a_valid_q || !m_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign adv             = a_valid_q && (!m_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;

  always_comb begin
    a_valid_d = a_valid_q;
    if (s_acc) begin
      a_valid_d = 1'b1;
    end else if (adv) begin
      a_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (adv) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  // error stage
  logic [CountW-1:0]         count;
  logic                      dir;
  logic signed [TargetW-1:0] target;
  logic signed [SpeedW-1:0]  speed;
  logic signed [ErrW-1:0]    err;
  logic signed [IntegW-1:0]  acc_sum;
  logic signed [IntegW-1:0]  lim_s;
  logic signed [IntegW-1:0]  integ_q, integ_d;
  logic signed [ErrW-1:0]    prev_q;
  err_stage_t                stage_d, stage_q;

  assign count  = s_axis_tdata_i[CountW-1:0];
  assign dir    = s_axis_tdata_i[CountW];
  assign target = $signed(s_axis_tdata_i[CountW+TargetW:CountW+1]);

  assign speed   = dir ? -$signed({1'b0, count}) : $signed({1'b0, count});
  assign err     = ErrW'(target) - ErrW'(speed);
  assign acc_sum = integ_q + IntegW'(err);
  assign lim_s   = $signed({{(IntegW-LimitW){1'b0}}, lim_q});

  always_comb begin
    if (acc_sum > lim_s) begin
      integ_d = lim_s;
    end else if (acc_sum < -lim_s) begin
      integ_d = -lim_s;
    end else begin
      integ_d = acc_sum;
    end
    stage_d.speed = speed;
    stage_d.err   = err;
    stage_d.acc   = integ_d;
    stage_d.diff  = DiffW'(err) - DiffW'(prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (s_acc) begin
      integ_q <= integ_d;
      prev_q  <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      stage_q <= stage_d;
    end
  end

  // control law stage
  gains_t  gains;
  result_t result;
  result_t out_q;

  assign gains.prop  = gain_prop_q;
  assign gains.integ = gain_integ_q;
  assign gains.deriv = gain_deriv_q;

  mspl_law u_law (
    .stage_i  (stage_q),
    .gains_i  (gains),
    .result_o (result)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tdata_o = {1'b0, out_q.duty_rev, out_q.duty_fwd, out_q.drive, out_q.speed};

  // checks
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (integ_q <= $past(lim_s)) && (integ_q >= -$past(lim_s)))
    else $error("integral outside limit after a tick");

  a_duty_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_q.duty_fwd == '0) || (out_q.duty_rev == '0))
    else $error("both duty channels active");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && m_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while pipeline full and stalled");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !adv && !s_acc) |=> a_valid_q && $stable(stage_q))
    else $error("pending error stage lost");

endmodule
